// ===== hdl/psmc_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the motion conditioner.
package psmc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_REST_BAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIFT_SHIFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PERCENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_EXCHANGE_AXES = 3'd6;

    localparam logic [14:0] REST_BAND_RST    = 15'd0;
    localparam logic [3:0]  DRIFT_SHIFT_RST  = 4'd4;
    localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd1000;
    localparam logic [9:0]  GAIN_PERCENT_RST = 10'd100;

    // Rounding bias for the Q8 offsets and for the percent division.
    localparam logic [25:0] Q8_HALF      = 26'd128;
    localparam logic [25:0] PERCENT_HALF = 26'd50;

    // floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for every n below 2**26
    localparam logic [26:0] RECIP_100   = 27'd85899346;
    localparam int unsigned RECIP_SHIFT = 33;

    localparam logic [19:0] SAT_POS = 20'd32767;
    localparam logic [19:0] SAT_NEG = 20'd32768;

    typedef struct packed {
        logic [14:0] rest_band;
        logic [3:0]  drift_shift;
        logic [15:0] idle_timeout;
        logic [9:0]  gain_percent;
        logic        flip_x;
        logic        flip_y;
        logic        exchange_axes;
    } cfg_t;

    // Result of the front stage: oriented motion and mode flags
    typedef struct packed {
        logic signed [16:0] vx;
        logic signed [16:0] vy;
        logic               moving;
        logic               fast;
    } front_out_t;

    typedef struct packed {
        logic load_b;
        logic load_c;
    } lane_ctrl_t;

    // Round a Q8 offset to an integer, kept to 16 bits with wrap.
    function automatic logic [15:0] round_off(input logic [24:0] q);
        logic [25:0] t;
        t = {q[24], q} + Q8_HALF;
        return t[23:8];
    endfunction

    // Magnitude of a 16-bit signed value; the most negative value gives 32768.
    function automatic logic [16:0] mag17(input logic [15:0] v);
        logic [16:0] w;
        w = {v[15], v};
        return v[15] ? (17'd0 - w) : w;
    endfunction

    // One IIR step of a Q8 drift offset toward the raw sample.
    function automatic logic [24:0] drift_step(input logic [24:0] q,
                                               input logic [15:0] r,
                                               input logic [3:0]  sh);
        logic signed [25:0] tgt;
        logic signed [25:0] cur;
        logic signed [25:0] diff;
        logic signed [25:0] sum;
        tgt  = {{2{r[15]}}, r, 8'd0};
        cur  = {q[24], q};
        diff = (tgt - cur) >>> sh;
        sum  = cur + diff;
        return sum[24:0];
    endfunction

endpackage

// ===== hdl/psmc_front.sv =====
// Front stage: drift removal, learning, dead zone, orientation and mode tracking.
module psmc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psmc_pkg::cfg_t        cfg,
    input  logic                  accept,
    input  logic [15:0]           raw_x,
    input  logic [15:0]           raw_y,
    input  logic [7:0]            button_bits,
    input  logic [31:0]           stamp_ms,
    output psmc_pkg::front_out_t  res
);

    logic [24:0] drift_x_reg, drift_x_next;
    logic [24:0] drift_y_reg, drift_y_next;
    logic        fast_reg, fast_next;
    logic [31:0] last_motion_reg, last_motion_next;

    logic [15:0] cx0, cy0, cx, cy;
    logic [16:0] dz17;
    logic        learn;
    logic        idle;
    logic        moved;
    logic        timed_out;
    logic [24:0] learn_x, learn_y;
    logic [16:0] sx, sy, ox, oy;

    always_comb
    begin
        dz17 = {2'b00, cfg.rest_band};
        cx0  = raw_x - psmc_pkg::round_off(drift_x_reg);
        cy0  = raw_y - psmc_pkg::round_off(drift_y_reg);

        learn = !fast_reg && (button_bits == 8'd0)
                && (psmc_pkg::mag17(cx0) < dz17) && (psmc_pkg::mag17(cy0) < dz17);

        learn_x = psmc_pkg::drift_step(drift_x_reg, raw_x, cfg.drift_shift);
        learn_y = psmc_pkg::drift_step(drift_y_reg, raw_y, cfg.drift_shift);

        drift_x_next = learn ? learn_x : drift_x_reg;
        drift_y_next = learn ? learn_y : drift_y_reg;

        // redo compensation with the offsets just learnt
        cx = raw_x - psmc_pkg::round_off(drift_x_next);
        cy = raw_y - psmc_pkg::round_off(drift_y_next);

        idle  = (psmc_pkg::mag17(cx) < dz17) && (psmc_pkg::mag17(cy) < dz17);
        moved = !idle && ((cx != 16'd0) || (cy != 16'd0));

        timed_out = (stamp_ms - last_motion_reg) > {16'd0, cfg.idle_timeout};

        fast_next        = moved ? 1'b1 : (fast_reg && !timed_out);
        last_motion_next = moved ? stamp_ms : last_motion_reg;

        // exchange, then negate at full width
        sx = cfg.exchange_axes ? {cy[15], cy} : {cx[15], cx};
        sy = cfg.exchange_axes ? {cx[15], cx} : {cy[15], cy};
        ox = cfg.flip_x ? (17'd0 - sx) : sx;
        oy = cfg.flip_y ? (17'd0 - sy) : sy;

        res.vx     = moved ? ox : 17'd0;
        res.vy     = moved ? oy : 17'd0;
        res.moving = moved;
        res.fast   = fast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_x_reg     <= '0;
            drift_y_reg     <= '0;
            fast_reg        <= 1'b0;
            last_motion_reg <= '0;
        end
        else if (accept)
        begin
            drift_x_reg     <= drift_x_next;
            drift_y_reg     <= drift_y_next;
            fast_reg        <= fast_next;
            last_motion_reg <= last_motion_next;
        end
    end

endmodule

// ===== hdl/psmc_lane.sv =====
// Scaling lane: percent gain, round half away from zero, saturate to 16 bits.
module psmc_lane (
    input  logic                  clk,
    input  psmc_pkg::lane_ctrl_t  ctrl,
    input  logic signed [16:0]    value,
    input  logic [9:0]            gain_percent,
    output logic [15:0]           scaled
);

    logic signed [27:0] prod;
    logic signed [27:0] prod_mag;
    logic [25:0]        mag_next, mag_reg;
    logic               neg_next, neg_reg;
    logic [52:0]        quot_prod;
    logic [19:0]        quot;
    logic [15:0]        scaled_next, scaled_reg;

    always_comb
    begin
        prod     = value * $signed({1'b0, gain_percent});
        prod_mag = prod[27] ? (28'sd0 - prod) : prod;
        mag_next = prod_mag[25:0] + psmc_pkg::PERCENT_HALF;
        neg_next = prod[27];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_b)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
        end
    end

    // divide by 100 through the reciprocal, then clamp
    always_comb
    begin
        quot_prod = 53'(mag_reg) * 53'(psmc_pkg::RECIP_100);
        quot      = quot_prod[psmc_pkg::RECIP_SHIFT +: 20];
        if (!neg_reg)
            scaled_next = (quot > psmc_pkg::SAT_POS) ? 16'h7FFF : quot[15:0];
        else
            scaled_next = (quot > psmc_pkg::SAT_NEG) ? 16'h8000 : (16'd0 - quot[15:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_c)
            scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

// ===== hdl/pointing_stick_motion_conditioner.sv =====
// Pointing-stick motion conditioner: one sample per clock unless the output stalls.
// Samples pass the front register and the lane registers; the drift offsets and the
// fast/slow mode are updated in the front stage in the cycle the sample is taken, so
// samples may follow each other on every clock; two scaling lanes (one per axis) then
// multiply by the gain and divide by 100 over two registered stages, and the output
// register merges both lanes with the motion and mode flags. The output register holds
// a result while the consumer stalls and the stages in front keep filling.
// Configuration writes take effect at once and are meant for idle periods only.
module pointing_stick_motion_conditioner (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [psmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psmc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [15:0]                raw_x,
    input  logic signed [15:0]                raw_y,
    input  logic [7:0]                        button_bits,
    input  logic [31:0]                       stamp_ms,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [15:0]                move_x,
    output logic signed [15:0]                move_y,
    output logic                              moving,
    output logic                              fast_poll
);

    psmc_pkg::cfg_t        cfg_reg;
    psmc_pkg::front_out_t  front_res;
    psmc_pkg::front_out_t  a_reg;
    psmc_pkg::lane_ctrl_t  lane_ctrl;

    logic va_reg, va_next;
    logic vb_reg, vb_next;
    logic vc_reg, vc_next;
    logic adv_a, adv_b, adv_c;
    logic accept;
    logic moving_b_reg, fast_b_reg;
    logic moving_c_reg, fast_c_reg;
    logic [15:0] lane_x, lane_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rest_band     <= psmc_pkg::REST_BAND_RST;
            cfg_reg.drift_shift   <= psmc_pkg::DRIFT_SHIFT_RST;
            cfg_reg.idle_timeout  <= psmc_pkg::IDLE_TIMEOUT_RST;
            cfg_reg.gain_percent  <= psmc_pkg::GAIN_PERCENT_RST;
            cfg_reg.flip_x        <= 1'b0;
            cfg_reg.flip_y        <= 1'b0;
            cfg_reg.exchange_axes <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psmc_pkg::REG_REST_BAND:     cfg_reg.rest_band     <= cfg_data[14:0];
                psmc_pkg::REG_DRIFT_SHIFT:   cfg_reg.drift_shift   <= cfg_data[3:0];
                psmc_pkg::REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout  <= cfg_data[15:0];
                psmc_pkg::REG_GAIN_PERCENT:  cfg_reg.gain_percent  <= cfg_data[9:0];
                psmc_pkg::REG_FLIP_X:        cfg_reg.flip_x        <= cfg_data[0];
                psmc_pkg::REG_FLIP_Y:        cfg_reg.flip_y        <= cfg_data[0];
                psmc_pkg::REG_EXCHANGE_AXES: cfg_reg.exchange_axes <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // advance a stage when it is empty or the stage after it moves on
    always_comb
    begin
        adv_c   = !vc_reg || out_ready;
        adv_b   = !vb_reg || adv_c;
        adv_a   = !va_reg || adv_b;
        accept  = in_valid && adv_a;
        va_next = adv_a ? in_valid : va_reg;
        vb_next = adv_b ? va_reg : vb_reg;
        vc_next = adv_c ? vb_reg : vc_reg;
        lane_ctrl.load_b = adv_b;
        lane_ctrl.load_c = adv_c;
    end

    assign in_ready = adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
        end
    end

    psmc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .raw_x       (raw_x),
        .raw_y       (raw_y),
        .button_bits (button_bits),
        .stamp_ms    (stamp_ms),
        .res         (front_res)
    );

    always_ff @(posedge clk)
    begin
        if (adv_a)
            a_reg <= front_res;
        if (adv_b)
        begin
            moving_b_reg <= a_reg.moving;
            fast_b_reg   <= a_reg.fast;
        end
        if (adv_c)
        begin
            moving_c_reg <= moving_b_reg;
            fast_c_reg   <= fast_b_reg;
        end
    end

    psmc_lane u_lane_x (
        .clk          (clk),
        .ctrl         (lane_ctrl),
        .value        (a_reg.vx),
        .gain_percent (cfg_reg.gain_percent),
        .scaled       (lane_x)
    );

    psmc_lane u_lane_y (
        .clk          (clk),
        .ctrl         (lane_ctrl),
        .value        (a_reg.vy),
        .gain_percent (cfg_reg.gain_percent),
        .scaled       (lane_y)
    );

    assign out_valid = vc_reg;
    assign move_x    = lane_x;
    assign move_y    = lane_y;
    assign moving    = moving_c_reg;
    assign fast_poll = fast_c_reg;

endmodule

// ===== hdl/psmc_checker.sv =====
// Port-level checks for the motion conditioner, bound to the top level.
module psmc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic signed [15:0]  move_x,
    input logic signed [15:0]  move_y,
    input logic                moving,
    input logic                fast_poll
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(move_x) && $stable(move_y)
            && $stable(moving) && $stable(fast_poll))
        else $error("output beat changed while stalled");

    a_still_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !moving |-> move_x == 16'sd0 && move_y == 16'sd0)
        else $error("motion reported without the moving flag");

    a_motion_fast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && moving |-> fast_poll)
        else $error("motion beat left slow mode set");

    // input is refused only when the whole pipe is full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused with room in the pipe");

endmodule

bind pointing_stick_motion_conditioner psmc_checker u_psmc_checker (.*);
